[rtl/core/gdp_pkg.sv]
// ----------------------------------------------------------------------------
// Grouped int4 x int8 dot product: shared package
// Widths, code constants and the control bundle passed from the stage-1
// pipeline to the merging accumulator.
// ----------------------------------------------------------------------------
package gdp_pkg;

  localparam int unsigned FIELD_W   = 64;  // width of each packed input field
  localparam int unsigned BYTE_W    = 8;   // one weight byte / one activation
  localparam int unsigned NIBBLE_W  = 4;   // one weight code
  localparam int unsigned CODE_W    = NIBBLE_W + 1;  // code minus bias, signed
  localparam int unsigned CODE_BIAS = 8;   // codes are stored as value plus 8
  localparam int unsigned LANE_W    = 13;  // two 5x8 products summed, signed
  localparam int unsigned DOT_W     = 32;  // width of the emitted group sum

  // Control that moves a lane result into the accumulator.
  typedef struct packed {
    logic advance;  // stage-1 item moves into the accumulator this cycle
    logic last;     // that item closes its group
  } acc_ctrl_t;

endpackage

[rtl/core/int4_int8_group_dot_product.sv]
// Throughput: 1 item per cycle while no last-of-group item waits on the output
//   register; set by the lane multipliers (stage 1) and the merge adder tree plus
//   accumulator (stage 2).
// Output register stalls only last-of-group items; other items keep flowing.
// Reset (rst_ni low, async): pipeline valids drop and the accumulator clears to zero.
// ----------------------------------------------------------------------------
// Grouped int4 x int8 dot product
// Streams one quantization group of packed int4 weights against int8
// activations and emits the wrapped group sum on the group's last item.
// ----------------------------------------------------------------------------
module int4_int8_group_dot_product #(
  parameter int unsigned BYTES_PER_ITEM = 8,
  parameter int unsigned SUM_WIDTH      = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // input item channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [gdp_pkg::FIELD_W-1:0]         weight_bytes_i,
  input  logic [gdp_pkg::FIELD_W-1:0]         even_acts_i,
  input  logic [gdp_pkg::FIELD_W-1:0]         odd_acts_i,
  input  logic                                last_of_group_i,
  // result item channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [gdp_pkg::DOT_W-1:0]    group_dot_o
);

  // Stage 1 control: valid and group marker of the item held in the lanes.
  logic s1_valid_d, s1_valid_q;
  logic s1_last_q;
  // Output register valid.
  logic out_valid_d, out_valid_q;

  logic               in_accept;
  logic               out_free;
  logic               s1_advance;
  gdp_pkg::acc_ctrl_t acc_ctrl;

  logic signed [gdp_pkg::LANE_W-1:0] lane_part [BYTES_PER_ITEM];

  // A stage-1 item may move on unless it closes a group and the output
  // register still holds an untaken result.
  assign out_free   = !out_valid_q || out_ready_i;
  assign s1_advance = s1_valid_q && (!s1_last_q || out_free);
  assign in_ready_o = !s1_valid_q || s1_advance;
  assign in_accept  = in_valid_i && in_ready_o;

  assign acc_ctrl.advance = s1_advance;
  assign acc_ctrl.last    = s1_last_q;

  // Lanes: one per weight byte; higher bytes of the wide fields are ignored.
  for (genvar g = 0; g < BYTES_PER_ITEM; g++) begin : g_lane
    gdp_lane u_lane (
      .clk_i         (clk_i),
      .load_i        (in_accept),
      .weight_byte_i (weight_bytes_i[g*gdp_pkg::BYTE_W +: gdp_pkg::BYTE_W]),
      .even_act_i    (signed'(even_acts_i[g*gdp_pkg::BYTE_W +: gdp_pkg::BYTE_W])),
      .odd_act_i     (signed'(odd_acts_i[g*gdp_pkg::BYTE_W +: gdp_pkg::BYTE_W])),
      .part_q_o      (lane_part[g])
    );
  end

  // Merge: adder tree, wrapping accumulator and result register.
  gdp_merge #(
    .BYTES_PER_ITEM (BYTES_PER_ITEM),
    .SUM_WIDTH      (SUM_WIDTH)
  ) u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (acc_ctrl),
    .part_i      (lane_part),
    .group_dot_o (group_dot_o)
  );

  // Hold stage 1 while stalled, load on accept, drop once advanced.
  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_advance) begin
      s1_valid_d = 1'b0;
    end
  end

  // Raise output valid on a group close, drop it once taken.
  always_comb begin
    out_valid_d = out_valid_q;
    if (s1_advance && s1_last_q) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_last_q <= last_of_group_i;
    end
  end

  assign out_valid_o = out_valid_q;

`ifndef SYNTHESIS
  // A group close never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_advance && s1_last_q && out_valid_q && !out_ready_i))
    else $error("group result overwritten while stalled");

  // A new result appears only after a closing item left stage 1.
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_advance && s1_last_q))
    else $error("result valid without a closing item");

  // Backpressure on the input only comes from an occupied stage 1.
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (s1_valid_q && s1_last_q && out_valid_q && !out_ready_i))
    else $error("input stalled without a blocked closing item");
`endif

endmodule

[rtl/core/gdp_lane.sv]
// ----------------------------------------------------------------------------
// Grouped int4 x int8 dot product: one lane
// Unpacks one weight byte into two codes, removes their bias, multiplies each by its
// activation and registers the sum of both products.
// ----------------------------------------------------------------------------
module gdp_lane (
  input  logic                                     clk_i,
  input  logic                                     load_i,
  input  logic [gdp_pkg::BYTE_W-1:0]               weight_byte_i,
  input  logic signed [gdp_pkg::BYTE_W-1:0]        even_act_i,
  input  logic signed [gdp_pkg::BYTE_W-1:0]        odd_act_i,
  output logic signed [gdp_pkg::LANE_W-1:0]        part_q_o
);

  logic signed [gdp_pkg::CODE_W-1:0] lo_code;
  logic signed [gdp_pkg::CODE_W-1:0] hi_code;
  logic signed [gdp_pkg::LANE_W-1:0] lo_prod;
  logic signed [gdp_pkg::LANE_W-1:0] hi_prod;
  logic signed [gdp_pkg::LANE_W-1:0] part_d;
  logic signed [gdp_pkg::LANE_W-1:0] part_q;

  // Remove the bias: code - 8 lies in -8..7.
  assign lo_code = signed'(gdp_pkg::CODE_W'(weight_byte_i[gdp_pkg::NIBBLE_W-1:0]))
                   - signed'(gdp_pkg::CODE_W'(gdp_pkg::CODE_BIAS));
  assign hi_code = signed'(gdp_pkg::CODE_W'(weight_byte_i[gdp_pkg::BYTE_W-1:gdp_pkg::NIBBLE_W]))
                   - signed'(gdp_pkg::CODE_W'(gdp_pkg::CODE_BIAS));

  assign lo_prod = gdp_pkg::LANE_W'(lo_code) * gdp_pkg::LANE_W'(even_act_i);
  assign hi_prod = gdp_pkg::LANE_W'(hi_code) * gdp_pkg::LANE_W'(odd_act_i);
  assign part_d  = lo_prod + hi_prod;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      part_q <= part_d;
    end
  end

  assign part_q_o = part_q;

endmodule

[rtl/core/gdp_merge.sv]
// ----------------------------------------------------------------------------
// Grouped int4 x int8 dot product: merging accumulator
// Sums the lane results, adds them into the wrapping group accumulator and
// captures the group sum on the last item of a group.
// ----------------------------------------------------------------------------
module gdp_merge #(
  parameter int unsigned BYTES_PER_ITEM = 8,
  parameter int unsigned SUM_WIDTH      = 32
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  gdp_pkg::acc_ctrl_t                   ctrl_i,
  input  logic signed [gdp_pkg::LANE_W-1:0]    part_i [BYTES_PER_ITEM],
  output logic signed [gdp_pkg::DOT_W-1:0]     group_dot_o
);

  localparam int unsigned TREE_W = gdp_pkg::LANE_W + $clog2(BYTES_PER_ITEM) + 1;

  logic signed [TREE_W-1:0]        tree_sum;
  logic [SUM_WIDTH-1:0]            tree_ext;
  logic [SUM_WIDTH-1:0]            acc_sum;
  logic [SUM_WIDTH-1:0]            acc_d;
  logic [SUM_WIDTH-1:0]            acc_q;
  logic [gdp_pkg::DOT_W-1:0]       dot_d;
  logic [gdp_pkg::DOT_W-1:0]       dot_q;

  always_comb begin
    tree_sum = '0;
    for (int i = 0; i < BYTES_PER_ITEM; i++) begin
      tree_sum = tree_sum + TREE_W'(part_i[i]);
    end
  end

  assign tree_ext = {{(SUM_WIDTH-TREE_W){tree_sum[TREE_W-1]}}, tree_sum};
  assign acc_sum  = acc_q + tree_ext;

  // Sign-extend a narrow accumulator, keep the low bits of a wide one.
  if (SUM_WIDTH >= gdp_pkg::DOT_W) begin : g_dot_trunc
    assign dot_d = acc_sum[gdp_pkg::DOT_W-1:0];
  end else begin : g_dot_ext
    assign dot_d = {{(gdp_pkg::DOT_W-SUM_WIDTH){acc_sum[SUM_WIDTH-1]}}, acc_sum};
  end

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.advance) begin
      acc_d = ctrl_i.last ? '0 : acc_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.advance && ctrl_i.last) begin
      dot_q <= dot_d;
    end
  end

  assign group_dot_o = signed'(dot_q);

endmodule

[tb/int4_int8_group_dot_product_tb.sv]
// ----------------------------------------------------------------------------
// Grouped int4 x int8 dot product: testbench
// Drives packed weight and activation items with random valid/ready gaps and
// checks every emitted group sum against a bit-accurate predictor or a hand value.
// ----------------------------------------------------------------------------
module int4_int8_group_dot_product_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NUM_BYTES    = 8;
  localparam int unsigned SUM_W        = 32;
  localparam int          BIAS         = int'(gdp_pkg::CODE_BIAS);
  localparam int          RESET_CYCLES = 12;
  localparam int          DRAIN_CYCLES = 8;     // window to watch for stray results
  localparam int          STALL_LIMIT  = 1000;  // cycles with no item moving
  localparam int          RANDOM_ITEMS = 780;

  // One directed row; typed marks a hand-computed group sum.
  typedef struct packed {
    logic [63:0]        wts;
    logic [63:0]        evens;
    logic [63:0]        odds;
    logic               last;
    logic               typed;
    logic signed [31:0] dot;
  } plan_row_t;

  localparam int PLAN_ROWS = 19;
  localparam plan_row_t DIRECTED_PLAN [PLAN_ROWS] = '{
    // Single-item groups at the corners of code and activation range.
    '{64'h0000000000000000, 64'h8080808080808080, 64'h8080808080808080,
      1'b1, 1'b1, 32'sd16384},
    '{64'hFFFFFFFFFFFFFFFF, 64'h7F7F7F7F7F7F7F7F, 64'h7F7F7F7F7F7F7F7F,
      1'b1, 1'b1, 32'sd14224},
    '{64'h0000000000000000, 64'h7F7F7F7F7F7F7F7F, 64'h7F7F7F7F7F7F7F7F,
      1'b1, 1'b1, -32'sd16256},
    '{64'hFFFFFFFFFFFFFFFF, 64'h8080808080808080, 64'h8080808080808080,
      1'b1, 1'b1, -32'sd14336},
    // Code 8 stands for zero, whatever the activations.
    '{64'h8888888888888888, 64'h5A3C96E107F8C32D, 64'hA5C3691EF8073CD2,
      1'b1, 1'b1, 32'sd0},
    // Opposite extremes on the two nibbles of each byte.
    '{64'h0F0F0F0F0F0F0F0F, 64'h7F7F7F7F7F7F7F7F, 64'h8080808080808080,
      1'b1, 1'b1, 32'sd15304},
    '{64'hF0F0F0F0F0F0F0F0, 64'h7F7F7F7F7F7F7F7F, 64'h8080808080808080,
      1'b1, 1'b1, -32'sd15296},
    // Zero activations.
    '{64'h0123456789ABCDEF, 64'h0000000000000000, 64'h0000000000000000,
      1'b1, 1'b1, 32'sd0},
    // Lone lanes: byte 0 low nibble, byte 7 high nibble.
    '{64'h8888888888888889, 64'hFFFFFFFFFFFFFF01, 64'h0000000000000000,
      1'b1, 1'b1, 32'sd1},
    '{64'h1888888888888888, 64'h0000000000000000, 64'h8055555555555555,
      1'b1, 1'b1, 32'sd896},
    // Multi-item groups; sums come from the predictor.
    '{64'h0123456789ABCDEF, 64'h0102030405060708, 64'hF0E0D0C0B0A09080,
      1'b0, 1'b0, 32'sd0},
    '{64'hFEDCBA9876543210, 64'h80FF7F0001FE8102, 64'h7F80FF0102030405,
      1'b0, 1'b0, 32'sd0},
    '{64'h0000000000000000, 64'h8080808080808080, 64'h8080808080808080,
      1'b0, 1'b0, 32'sd0},
    '{64'hFFFFFFFFFFFFFFFF, 64'h7F7F7F7F7F7F7F7F, 64'h7F7F7F7F7F7F7F7F,
      1'b1, 1'b0, 32'sd0},
    '{64'h7777777777777777, 64'h1122334455667788, 64'h99AABBCCDDEEFF00,
      1'b0, 1'b0, 32'sd0},
    '{64'h0000000000000000, 64'h7F7F7F7F7F7F7F7F, 64'h7F7F7F7F7F7F7F7F,
      1'b0, 1'b0, 32'sd0},
    '{64'h0000000000000000, 64'h7F7F7F7F7F7F7F7F, 64'h7F7F7F7F7F7F7F7F,
      1'b1, 1'b0, 32'sd0},
    '{64'hA5A5A5A5A5A5A5A5, 64'hC3C3C3C3C3C3C3C3, 64'h3C3C3C3C3C3C3C3C,
      1'b1, 1'b0, 32'sd0},
    // All activations -1 against zero codes.
    '{64'h8888888888888888, 64'hFFFFFFFFFFFFFFFF, 64'hFFFFFFFFFFFFFFFF,
      1'b1, 1'b1, 32'sd0}
  };

  logic                               clk;
  logic                               rst_ni;
  logic                               in_valid;
  logic                               in_ready;
  logic [gdp_pkg::FIELD_W-1:0]        weight_bytes;
  logic [gdp_pkg::FIELD_W-1:0]        even_acts;
  logic [gdp_pkg::FIELD_W-1:0]        odd_acts;
  logic                               last_of_group;
  logic                               out_valid;
  logic                               out_ready;
  logic signed [gdp_pkg::DOT_W-1:0]   group_dot;

  // Predictor state: open-group sum and the group sums still owed by the block.
  logic [SUM_W-1:0]                   group_sum;
  logic signed [31:0]                 pending_dots[$];
  int                                 mismatch_count;
  int                                 quiet_cycles;
  bit                                 no_gaps;  // suppress idling on both sides

  int4_int8_group_dot_product #(
    .BYTES_PER_ITEM(NUM_BYTES),
    .SUM_WIDTH     (SUM_W)
  ) uut (
    .clk_i          (clk),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .weight_bytes_i (weight_bytes),
    .even_acts_i    (even_acts),
    .odd_acts_i     (odd_acts),
    .last_of_group_i(last_of_group),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .group_dot_o    (group_dot)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Sum of (code - 8) * activation over both nibbles of every used byte,
  // wrapped to the accumulator width.
  function automatic logic [SUM_W-1:0] item_partial_sum(input logic [63:0] wts,
                                                        input logic [63:0] evens,
                                                        input logic [63:0] odds);
    logic [SUM_W-1:0]  sum;
    logic [7:0]        wb;
    logic signed [7:0] ea;
    logic signed [7:0] oa;
    int                lo;
    int                hi;
    sum = '0;
    for (int i = 0; i < NUM_BYTES; i++) begin
      wb  = wts[8*i +: 8];
      ea  = evens[8*i +: 8];
      oa  = odds[8*i +: 8];
      lo  = int'(wb[gdp_pkg::NIBBLE_W-1:0]) - BIAS;
      hi  = int'(wb[7:gdp_pkg::NIBBLE_W]) - BIAS;
      sum += SUM_W'(lo * ea + hi * oa);
    end
    return sum;
  endfunction

  // Fold an accepted item into the open group; on the last item queue the
  // sign-extended low 32 bits (or the hand value) and clear the group.
  task automatic absorb_item(input logic [63:0] wts, input logic [63:0] evens,
                             input logic [63:0] odds, input bit last,
                             input bit typed, input logic signed [31:0] typed_dot);
    logic signed [63:0] wide;
    group_sum += item_partial_sum(wts, evens, odds);
    if (last) begin
      wide = $signed(group_sum);
      pending_dots.push_back(typed ? typed_dot : wide[31:0]);
      group_sum = '0;
    end
  endtask

  // Mostly short gaps, now and then a long one.
  function automatic int idle_length();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    else if (pick < 95) return $urandom_range(4, 10);
    else return $urandom_range(20, 60);
  endfunction

  // Per byte: favor the corners 00/FF/80/7F, otherwise any value.
  function automatic logic [63:0] random_lanes();
    logic [63:0] v;
    for (int i = 0; i < 8; i++) begin
      case ($urandom_range(0, 7))
        0:       v[8*i +: 8] = 8'h80;
        1:       v[8*i +: 8] = 8'h7F;
        2:       v[8*i +: 8] = 8'h00;
        3:       v[8*i +: 8] = 8'hFF;
        default: v[8*i +: 8] = 8'($urandom_range(0, 255));
      endcase
    end
    return v;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with valid still high so a back-to-back item can follow without a bubble.
  task automatic send_item(input logic [63:0] wts, input logic [63:0] evens,
                           input logic [63:0] odds, input bit last,
                           input bit typed, input logic signed [31:0] typed_dot);
    int gap;
    gap = (!no_gaps && $urandom_range(0, 2) == 0) ? idle_length() : 0;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid      = 1'b1;
    weight_bytes  = wts;
    even_acts     = evens;
    odd_acts      = odds;
    last_of_group = last;
    // Hold the item until the block takes it.
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    absorb_item(wts, evens, odds, last, typed, typed_dot);
    @(negedge clk);
  endtask

  // Result side: drop ready for random stretches unless gaps are suppressed.
  initial begin
    int stall;
    stall     = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
        out_ready = 1'b0;
        stall     = idle_length() - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  // Compare every accepted group sum with the oldest one owed.
  always @(posedge clk) begin
    logic signed [31:0] want;
    if (rst_ni && out_valid && out_ready) begin
      if (pending_dots.size() == 0) begin
        $error("group_dot: expected none, actual %0d", group_dot);
        mismatch_count++;
      end else begin
        want = pending_dots.pop_front();
        if (group_dot !== want) begin
          $error("group_dot: expected %0d, actual %0d", want, group_dot);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int group_len;
    int sent;
    rst_ni         = 1'b0;
    in_valid       = 1'b0;
    weight_bytes   = '0;
    even_acts      = '0;
    odd_acts       = '0;
    last_of_group  = 1'b0;
    group_sum      = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    no_gaps        = 1'b0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_ni = 1'b1;

    // Directed rows: corners, zero codes, lone lanes, short groups.
    for (int i = 0; i < PLAN_ROWS; i++) begin
      send_item(DIRECTED_PLAN[i].wts, DIRECTED_PLAN[i].evens, DIRECTED_PLAN[i].odds,
                DIRECTED_PLAN[i].last, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].dot);
    end

    // Random groups: mostly short, some long; toggle idling between groups.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      no_gaps   = ($urandom_range(0, 5) == 0);
      group_len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                              : $urandom_range(1, 8);
      for (int k = 0; k < group_len; k++) begin
        send_item(random_lanes(), random_lanes(), random_lanes(),
                  k == group_len - 1, 1'b0, 32'sd0);
      end
      sent += group_len;
    end
    in_valid = 1'b0;
    no_gaps  = 1'b0;

    // Drain: wait for every owed sum, then watch for strays.
    while (pending_dots.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
